/* hw/rtl/dwhs_pkg.sv */
// Types, register indexes and reset values for the driver wake handshake sequencer.
package dwhs_pkg;

    // Configuration register indexes
    localparam int unsigned CfgIdxW = 3;
    localparam logic [CfgIdxW-1:0] REG_SLEEP_FORCE_TIME = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_READY_TIMEOUT    = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_ACK_TIMEOUT      = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_POLL_INTERVAL    = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_ACK_PULSE_TIME   = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_POLARITY_LEVEL   = 3'd5;

    localparam int unsigned CfgDataW = 16;
    localparam int unsigned CountW   = 16;
    localparam int unsigned ShortW   = 8;

    // Register values after reset
    localparam logic [CountW-1:0] RST_SLEEP_FORCE_TIME = 16'd2000;
    localparam logic [CountW-1:0] RST_READY_TIMEOUT    = 16'd5000;
    localparam logic [CountW-1:0] RST_ACK_TIMEOUT      = 16'd5000;
    localparam logic [ShortW-1:0] RST_POLL_INTERVAL    = 8'd10;
    localparam logic [ShortW-1:0] RST_ACK_PULSE_TIME   = 8'd22;
    localparam logic              RST_POLARITY_LEVEL   = 1'b0;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_FORCE = 3'd1,
        PH_READY = 3'd2,
        PH_PULSE = 3'd3,
        PH_ACK   = 3'd4
    } t_phase;

    typedef struct packed {
        logic [CountW-1:0] sleep_force_time;
        logic [CountW-1:0] ready_timeout;
        logic [CountW-1:0] ack_timeout;
        logic [ShortW-1:0] poll_interval;
        logic [ShortW-1:0] ack_pulse_time;
        logic              polarity_level;
    } t_cfg;

    typedef struct packed {
        t_phase            phase;
        logic [CountW-1:0] wait_count;
        logic [CountW-1:0] elapsed_time;
        logic              ready_seen;
        logic              sleep_level;
    } t_state;

    typedef struct packed {
        logic sleep_pin;
        logic polarity_pin;
        logic busy_res;
        logic finished;
        logic outcome;
    } t_result;

endpackage

/* hw/rtl/dwhs_step.sv */
// Next-state and result logic for one tick or start transfer of the wake sequencer.
module dwhs_step
    import dwhs_pkg::*;
(
    input  t_cfg    i_cfg,
    input  t_state  i_state,
    input  logic    i_action,
    input  logic    i_fault_level,
    input  logic    i_fault_read_ok,
    output t_state  o_state,
    output t_result o_result
);

    logic [CountW-1:0] w_inc;
    logic              w_wc_zero;
    logic              w_poll_wrap;
    logic [CountW:0]   w_el_sum;
    logic [CountW-1:0] w_el_sat;
    logic              w_force_done;
    logic              w_pulse_done;
    logic              w_ready_tmo;
    logic              w_ready_hit;
    logic              w_ack_tmo;
    logic              w_ack_hit;
    t_phase            n_phase;

    // Shared counter arithmetic
    assign w_inc        = i_state.wait_count + {{(CountW-1){1'b0}}, 1'b1};
    assign w_wc_zero    = (i_state.wait_count == '0);
    assign w_poll_wrap  = (w_inc >= {{(CountW-ShortW){1'b0}}, i_cfg.poll_interval});
    assign w_el_sum     = {1'b0, i_state.elapsed_time}
                        + {{(CountW+1-ShortW){1'b0}}, i_cfg.poll_interval};
    assign w_el_sat     = w_el_sum[CountW] ? {CountW{1'b1}} : w_el_sum[CountW-1:0];
    assign w_force_done = (w_inc >= i_cfg.sleep_force_time);
    assign w_pulse_done = (w_inc >= {{(CountW-ShortW){1'b0}}, i_cfg.ack_pulse_time});
    assign w_ready_tmo  = w_wc_zero && (i_state.elapsed_time >= i_cfg.ready_timeout);
    assign w_ready_hit  = w_wc_zero && i_fault_read_ok && !i_fault_level;
    assign w_ack_tmo    = w_wc_zero && (i_state.elapsed_time >= i_cfg.ack_timeout);
    assign w_ack_hit    = w_wc_zero && i_fault_read_ok && i_fault_level;

    // Next phase
    always_comb begin
        n_phase = i_state.phase;
        if (i_action) begin
            n_phase = PH_FORCE;
        end else begin
            case (i_state.phase)
                PH_FORCE: begin
                    if (w_force_done) n_phase = PH_READY;
                end
                PH_READY: begin
                    if (w_ready_tmo || w_ready_hit) n_phase = PH_PULSE;
                end
                PH_PULSE: begin
                    if (w_pulse_done) n_phase = i_state.ready_seen ? PH_ACK : PH_IDLE;
                end
                PH_ACK: begin
                    if (w_ack_tmo || w_ack_hit) n_phase = PH_IDLE;
                end
                default: n_phase = PH_IDLE;
            endcase
        end
    end

    // Counters, flags and result fields
    always_comb begin
        o_state          = i_state;
        o_state.phase    = n_phase;
        o_result.finished = 1'b0;
        o_result.outcome  = 1'b0;
        if (i_action) begin
            o_state.sleep_level  = 1'b0;
            o_state.wait_count   = '0;
            o_state.elapsed_time = '0;
            o_state.ready_seen   = 1'b0;
        end else begin
            case (i_state.phase)
                PH_FORCE: begin
                    o_state.wait_count = w_inc;
                    if (w_force_done) begin
                        o_state.sleep_level  = 1'b1;
                        o_state.wait_count   = '0;
                        o_state.elapsed_time = '0;
                    end
                end
                PH_READY: begin
                    if (w_ready_tmo || w_ready_hit) begin
                        o_state.sleep_level = 1'b0;
                        o_state.wait_count  = '0;
                        if (!w_ready_tmo) o_state.ready_seen = 1'b1;
                    end else if (w_poll_wrap) begin
                        o_state.wait_count   = '0;
                        o_state.elapsed_time = w_el_sat;
                    end else begin
                        o_state.wait_count = w_inc;
                    end
                end
                PH_PULSE: begin
                    o_state.wait_count = w_inc;
                    if (w_pulse_done) begin
                        o_state.sleep_level  = 1'b1;
                        o_state.wait_count   = '0;
                        o_state.elapsed_time = '0;
                        o_result.finished    = !i_state.ready_seen;
                    end
                end
                PH_ACK: begin
                    if (w_ack_tmo || w_ack_hit) begin
                        o_result.finished = 1'b1;
                        o_result.outcome  = !w_ack_tmo;
                    end else if (w_poll_wrap) begin
                        o_state.wait_count   = '0;
                        o_state.elapsed_time = w_el_sat;
                    end else begin
                        o_state.wait_count = w_inc;
                    end
                end
                default: begin
                end
            endcase
        end
        o_result.sleep_pin    = o_state.sleep_level;
        o_result.polarity_pin = i_cfg.polarity_level;
        o_result.busy_res     = (n_phase != PH_IDLE);
    end

endmodule

/* hw/rtl/driver_wake_handshake_sequencer.sv */
// Top level of the driver wake handshake sequencer: config registers, state and result register.
//
// Each input transfer is either a one-microsecond tick or a start request; the block
// answers every transfer with exactly one result. It takes one transfer per clock cycle
// while the output is not stalled: the phase, counters and result fields are worked out
// in one pass of compare-and-increment logic and land in the state registers and the
// result register at the same edge, so the result appears in the cycle after the transfer.
// The input side stalls only while a valid result is held by a stalled output.
module driver_wake_handshake_sequencer
    import dwhs_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // configuration write port
    input  logic                i_cfg_wr_en,
    input  logic [CfgIdxW-1:0]  i_cfg_index,
    input  logic [CfgDataW-1:0] i_cfg_data,
    // input channel
    input  logic                i_valid,
    output logic                o_stall,
    input  logic                i_action,
    input  logic                i_fault_level,
    input  logic                i_fault_read_ok,
    // result channel
    output logic                o_valid,
    input  logic                i_stall,
    output logic                o_sleep_pin,
    output logic                o_polarity_pin,
    output logic                o_busy_res,
    output logic                o_finished,
    output logic                o_outcome
);

    t_cfg    r_cfg;
    t_state  r_state;
    t_state  n_state;
    t_result r_result;
    t_result n_result;
    logic    r_valid;
    logic    w_accept;

    // Accept unless a held result cannot drain
    assign o_stall  = r_valid && i_stall;
    assign w_accept = i_valid && !o_stall;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sleep_force_time <= RST_SLEEP_FORCE_TIME;
            r_cfg.ready_timeout    <= RST_READY_TIMEOUT;
            r_cfg.ack_timeout      <= RST_ACK_TIMEOUT;
            r_cfg.poll_interval    <= RST_POLL_INTERVAL;
            r_cfg.ack_pulse_time   <= RST_ACK_PULSE_TIME;
            r_cfg.polarity_level   <= RST_POLARITY_LEVEL;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_SLEEP_FORCE_TIME: r_cfg.sleep_force_time <= i_cfg_data;
                REG_READY_TIMEOUT:    r_cfg.ready_timeout    <= i_cfg_data;
                REG_ACK_TIMEOUT:      r_cfg.ack_timeout      <= i_cfg_data;
                REG_POLL_INTERVAL:    r_cfg.poll_interval    <= i_cfg_data[ShortW-1:0];
                REG_ACK_PULSE_TIME:   r_cfg.ack_pulse_time   <= i_cfg_data[ShortW-1:0];
                REG_POLARITY_LEVEL:   r_cfg.polarity_level   <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    dwhs_step u_step (
        .i_cfg           (r_cfg),
        .i_state         (r_state),
        .i_action        (i_action),
        .i_fault_level   (i_fault_level),
        .i_fault_read_ok (i_fault_read_ok),
        .o_state         (n_state),
        .o_result        (n_result)
    );

    // Advance sequencer state on each accepted transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase        <= PH_IDLE;
            r_state.wait_count   <= '0;
            r_state.elapsed_time <= '0;
            r_state.ready_seen   <= 1'b0;
            r_state.sleep_level  <= 1'b1;
        end else if (w_accept) begin
            r_state <= n_state;
        end
    end

    // Hold result until the output transfer completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_result <= n_result;
        end
    end

    assign o_valid        = r_valid;
    assign o_sleep_pin    = r_result.sleep_pin;
    assign o_polarity_pin = r_result.polarity_pin;
    assign o_busy_res     = r_result.busy_res;
    assign o_finished     = r_result.finished;
    assign o_outcome      = r_result.outcome;

endmodule
